/* rtl/tbrc_pkg.sv */
// shared types and constants for the byte risc core
`timescale 1ns / 1ps

package tbrc_pkg;

    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 16;
    localparam int RIDX_W   = 4;
    localparam int MEM_DEPTH = 65536;
    localparam int RF_DEPTH  = 16;

    // action codes of an input word
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_EXEC  = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_MOD = 4'd3,
        OP_AND = 4'd4,
        OP_NOT = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_SAV = 4'd8,
        OP_LOD = 4'd9,
        OP_COP = 4'd10,
        OP_EQU = 4'd11,
        OP_GRT = 4'd12,
        OP_JMP = 4'd13,
        OP_JIF = 4'd14,
        OP_SET = 4'd15
    } opcode_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_WR_IN,
        MEM_RD_IN,
        MEM_RD_PC,
        MEM_RD_PC1,
        MEM_RD_PAIR,
        MEM_WR_PAIR,
        MEM_CLR
    } mem_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MEMOP,
        S_FETCH0,
        S_FETCH1,
        S_DECODE,
        S_OPREAD,
        S_EXEC,
        S_MOD,
        S_LOAD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic    in_load;
        logic    clr_en;
        mem_op_t mem_op;
        logic    ir0_load;
        logic    dec_load;
        logic    op_load;
        logic    mod_start;
        logic    commit;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        opcode_t    op;
        logic       mod_err;
        logic       mod_done;
        logic       clr_last;
    } dp_status_t;

endpackage

/* rtl/tiny_byte_risc_core_top.sv */
// top level of the byte risc core: controller, datapath and port wiring
`timescale 1ns / 1ps

// memory words pass S_MEMOP then S_RESP; instructions pass S_FETCH0, S_FETCH1,
// S_DECODE, S_OPREAD and S_EXEC, a load adds S_LOAD and a modulo S_MOD (bit-serial)
// one word in flight at a time; the single memory port carries both
// instruction bytes and the data access one after another; a stalled result holds
// reset: synchronous active-low aresetn; afterwards a clearing pass over all 65536
// memory bytes zeroes memory and registers with s_ready low, pc starts at 0

module tiny_byte_risc_core_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [tbrc_pkg::ADDR_W-1:0]  s_mem_address,
    input  logic [tbrc_pkg::DATA_W-1:0]  s_write_data,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [tbrc_pkg::DATA_W-1:0]  m_read_data,
    output logic [tbrc_pkg::ADDR_W-1:0]  m_pc_after,
    output logic                         m_reg_written,
    output logic [tbrc_pkg::RIDX_W-1:0]  m_reg_index,
    output logic [tbrc_pkg::DATA_W-1:0]  m_reg_value
);

    // command and status between sequencer and datapath
    tbrc_pkg::dp_cmd_t    dp_cmd;
    tbrc_pkg::dp_status_t dp_status;

    // sequencer: clearing pass, fetch/decode/execute, result handoff
    tbrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    // datapath: memory, register file, pc, alu, remainder unit, output register
    tbrc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .s_action      (s_action),
        .s_mem_address (s_mem_address),
        .s_write_data  (s_write_data),
        .m_status      (m_status),
        .m_read_data   (m_read_data),
        .m_pc_after    (m_pc_after),
        .m_reg_written (m_reg_written),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value)
    );

endmodule

/* rtl/tbrc_mod_unit.sv */
// bit-serial 8-bit remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module tbrc_mod_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tbrc_pkg::DATA_W-1:0]  dividend,
    input  logic [tbrc_pkg::DATA_W-1:0]  divisor,
    output logic                         done,
    output logic [tbrc_pkg::DATA_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(tbrc_pkg::DATA_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [tbrc_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [tbrc_pkg::DATA_W-1:0] dvd_reg, dvd_next;
    logic [tbrc_pkg::DATA_W-1:0] dvs_reg, dvs_next;
    logic [tbrc_pkg::DATA_W:0]   shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, dvd_reg[tbrc_pkg::DATA_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // restoring step: subtract when the shifted remainder covers the divisor
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = tbrc_pkg::DATA_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = shifted[tbrc_pkg::DATA_W-1:0];
            end
            dvd_next = {dvd_reg[tbrc_pkg::DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(tbrc_pkg::DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/tbrc_datapath.sv */
// datapath: memory, register file, program counter, alu and result registers
`timescale 1ns / 1ps

module tbrc_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tbrc_pkg::dp_cmd_t            cmd,
    output tbrc_pkg::dp_status_t         status,
    input  logic [1:0]                   s_action,
    input  logic [tbrc_pkg::ADDR_W-1:0]  s_mem_address,
    input  logic [tbrc_pkg::DATA_W-1:0]  s_write_data,
    output logic                         m_status,
    output logic [tbrc_pkg::DATA_W-1:0]  m_read_data,
    output logic [tbrc_pkg::ADDR_W-1:0]  m_pc_after,
    output logic                         m_reg_written,
    output logic [tbrc_pkg::RIDX_W-1:0]  m_reg_index,
    output logic [tbrc_pkg::DATA_W-1:0]  m_reg_value
);

    localparam int DW = tbrc_pkg::DATA_W;
    localparam int AW = tbrc_pkg::ADDR_W;
    localparam int RW = tbrc_pkg::RIDX_W;

    logic [DW-1:0] mem_array [tbrc_pkg::MEM_DEPTH];
    logic [DW-1:0] rf_array  [tbrc_pkg::RF_DEPTH];

    logic [1:0]    act_reg;
    logic [AW-1:0] addr_reg;
    logic [DW-1:0] wdata_reg;
    logic [AW-1:0] pc_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [DW-1:0] ir0_reg, ir1_reg;
    logic [DW-1:0] opa_reg, opb_reg;
    logic [DW-1:0] rf_rda_reg, rf_rdb_reg;
    logic [DW-1:0] mem_rdata_reg;

    logic          res_status_reg;
    logic          res_wr_reg;
    logic [RW-1:0] res_idx_reg;
    logic [DW-1:0] res_val_reg;

    logic          out_status_reg;
    logic [DW-1:0] out_rdata_reg;
    logic [AW-1:0] out_pc_reg;
    logic          out_wr_reg;
    logic [RW-1:0] out_idx_reg;
    logic [DW-1:0] out_val_reg;

    tbrc_pkg::opcode_t op;
    logic [RW-1:0]     dst;
    logic [AW-1:0]     pair;
    logic [AW-1:0]     pc_plus2;
    logic [AW-1:0]     pc_new;
    logic [DW-1:0]     alu_res;
    logic [2*DW-1:0]   product;
    logic              mod_err;
    logic              writes_reg;
    logic              mod_done;
    logic [DW-1:0]     mod_rem;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata;

    logic          rf_re_a, rf_re_b;
    logic [RW-1:0] rf_addr_a, rf_addr_b;

    assign op       = tbrc_pkg::opcode_t'(ir0_reg[DW-1:RW]);
    assign dst      = ir0_reg[RW-1:0];
    assign pair     = {opa_reg, opb_reg};
    assign pc_plus2 = pc_reg + AW'(2);
    assign product  = opa_reg * opb_reg;
    assign mod_err  = (op == tbrc_pkg::OP_MOD) && (opb_reg == '0);
    assign writes_reg = !(op inside {tbrc_pkg::OP_SAV, tbrc_pkg::OP_JMP, tbrc_pkg::OP_JIF});

    // memory port select
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = wdata_reg;
        case (cmd.mem_op)
            tbrc_pkg::MEM_WR_IN: begin
                mem_we = 1'b1;
            end
            tbrc_pkg::MEM_RD_IN: begin
                mem_re = 1'b1;
            end
            tbrc_pkg::MEM_RD_PC: begin
                mem_re   = 1'b1;
                mem_addr = pc_reg;
            end
            tbrc_pkg::MEM_RD_PC1: begin
                mem_re   = 1'b1;
                mem_addr = pc_reg + AW'(1);
            end
            tbrc_pkg::MEM_RD_PAIR: begin
                mem_re   = 1'b1;
                mem_addr = pair;
            end
            tbrc_pkg::MEM_WR_PAIR: begin
                mem_we    = 1'b1;
                mem_addr  = pair;
                mem_wdata = rf_rda_reg;
            end
            tbrc_pkg::MEM_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem_array[mem_addr];
        end
    end

    // register file reads: a and b from byte 1 at decode, then d
    always_comb begin
        rf_re_a   = cmd.dec_load | cmd.op_load;
        rf_re_b   = cmd.dec_load;
        rf_addr_a = cmd.dec_load ? mem_rdata_reg[DW-1:RW] : dst;
        rf_addr_b = mem_rdata_reg[RW-1:0];
    end

    always_comb begin
        case (op)
            tbrc_pkg::OP_ADD: alu_res = opa_reg + opb_reg;
            tbrc_pkg::OP_SUB: alu_res = opa_reg - opb_reg;
            tbrc_pkg::OP_MUL: alu_res = product[DW-1:0];
            tbrc_pkg::OP_MOD: alu_res = mod_rem;
            tbrc_pkg::OP_AND: alu_res = opa_reg & opb_reg;
            tbrc_pkg::OP_NOT: alu_res = ~opa_reg;
            tbrc_pkg::OP_OR:  alu_res = opa_reg | opb_reg;
            tbrc_pkg::OP_XOR: alu_res = opa_reg ^ opb_reg;
            tbrc_pkg::OP_LOD: alu_res = mem_rdata_reg;
            tbrc_pkg::OP_COP: alu_res = opa_reg;
            tbrc_pkg::OP_EQU: alu_res = (opa_reg == opb_reg) ? '1 : '0;
            tbrc_pkg::OP_GRT: alu_res = (opa_reg > opb_reg) ? '1 : '0;
            tbrc_pkg::OP_SET: alu_res = ir1_reg;
            default:          alu_res = '0;
        endcase
    end

    // jif sees the destination register in rf_rda_reg during the commit cycle
    always_comb begin
        pc_new = pc_plus2;
        if (op == tbrc_pkg::OP_JMP) begin
            pc_new = pair;
        end else if ((op == tbrc_pkg::OP_JIF) && (rf_rda_reg != '0)) begin
            pc_new = pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_en) begin
            rf_array[clr_cnt_reg[RW-1:0]] <= '0;
        end else if (cmd.commit && !mod_err && writes_reg) begin
            rf_array[dst] <= alu_res;
        end
        if (rf_re_a) begin
            rf_rda_reg <= rf_array[rf_addr_a];
        end
        if (rf_re_b) begin
            rf_rdb_reg <= rf_array[rf_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.commit && !mod_err) begin
                pc_reg <= pc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            act_reg        <= s_action;
            addr_reg       <= s_mem_address;
            wdata_reg      <= s_write_data;
            res_status_reg <= 1'b0;
            res_wr_reg     <= 1'b0;
            res_idx_reg    <= '0;
            res_val_reg    <= '0;
        end else if (cmd.commit) begin
            if (mod_err) begin
                res_status_reg <= 1'b1;
            end else if (writes_reg) begin
                res_wr_reg  <= 1'b1;
                res_idx_reg <= dst;
                res_val_reg <= alu_res;
            end
        end
        if (cmd.ir0_load) begin
            ir0_reg <= mem_rdata_reg;
        end
        if (cmd.dec_load) begin
            ir1_reg <= mem_rdata_reg;
        end
        if (cmd.op_load) begin
            opa_reg <= rf_rda_reg;
            opb_reg <= rf_rdb_reg;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_rdata_reg  <= (act_reg == tbrc_pkg::ACT_READ) ? mem_rdata_reg : '0;
            out_pc_reg     <= pc_reg;
            out_wr_reg     <= res_wr_reg;
            out_idx_reg    <= res_idx_reg;
            out_val_reg    <= res_val_reg;
        end
    end

    tbrc_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (opa_reg),
        .divisor   (opb_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        status.act      = act_reg;
        status.op       = op;
        status.mod_err  = mod_err;
        status.mod_done = mod_done;
        status.clr_last = (clr_cnt_reg == '1);
    end

    assign m_status      = out_status_reg;
    assign m_read_data   = out_rdata_reg;
    assign m_pc_after    = out_pc_reg;
    assign m_reg_written = out_wr_reg;
    assign m_reg_index   = out_idx_reg;
    assign m_reg_value   = out_val_reg;

endmodule

/* rtl/tbrc_ctrl.sv */
// controller state machine sequencing the datapath
`timescale 1ns / 1ps

module tbrc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tbrc_pkg::dp_cmd_t     cmd,
    input  tbrc_pkg::dp_status_t  status
);

    tbrc_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tbrc_pkg::S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mem_op   = tbrc_pkg::MEM_NONE;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        case (state_reg)
            tbrc_pkg::S_CLEAR: begin
                cmd.clr_en = 1'b1;
                cmd.mem_op = tbrc_pkg::MEM_CLR;
                if (status.clr_last) begin
                    state_next = tbrc_pkg::S_IDLE;
                end
            end
            tbrc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    if (s_action == tbrc_pkg::ACT_WRITE || s_action == tbrc_pkg::ACT_READ) begin
                        state_next = tbrc_pkg::S_MEMOP;
                    end else if (s_action == tbrc_pkg::ACT_EXEC) begin
                        state_next = tbrc_pkg::S_FETCH0;
                    end else begin
                        state_next = tbrc_pkg::S_RESP;
                    end
                end
            end
            tbrc_pkg::S_MEMOP: begin
                cmd.mem_op = (status.act == tbrc_pkg::ACT_WRITE) ? tbrc_pkg::MEM_WR_IN
                                                                 : tbrc_pkg::MEM_RD_IN;
                state_next = tbrc_pkg::S_RESP;
            end
            tbrc_pkg::S_FETCH0: begin
                cmd.mem_op = tbrc_pkg::MEM_RD_PC;
                state_next = tbrc_pkg::S_FETCH1;
            end
            tbrc_pkg::S_FETCH1: begin
                cmd.mem_op   = tbrc_pkg::MEM_RD_PC1;
                cmd.ir0_load = 1'b1;
                state_next   = tbrc_pkg::S_DECODE;
            end
            tbrc_pkg::S_DECODE: begin
                cmd.dec_load = 1'b1;
                state_next   = tbrc_pkg::S_OPREAD;
            end
            tbrc_pkg::S_OPREAD: begin
                cmd.op_load = 1'b1;
                state_next  = tbrc_pkg::S_EXEC;
            end
            tbrc_pkg::S_EXEC: begin
                if (status.op == tbrc_pkg::OP_MOD && !status.mod_err) begin
                    cmd.mod_start = 1'b1;
                    state_next    = tbrc_pkg::S_MOD;
                end else if (status.op == tbrc_pkg::OP_LOD) begin
                    cmd.mem_op = tbrc_pkg::MEM_RD_PAIR;
                    state_next = tbrc_pkg::S_LOAD;
                end else begin
                    if (status.op == tbrc_pkg::OP_SAV) begin
                        cmd.mem_op = tbrc_pkg::MEM_WR_PAIR;
                    end
                    cmd.commit = 1'b1;
                    state_next = tbrc_pkg::S_RESP;
                end
            end
            tbrc_pkg::S_MOD: begin
                if (status.mod_done) begin
                    cmd.commit = 1'b1;
                    state_next = tbrc_pkg::S_RESP;
                end
            end
            tbrc_pkg::S_LOAD: begin
                cmd.commit = 1'b1;
                state_next = tbrc_pkg::S_RESP;
            end
            tbrc_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = tbrc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tbrc_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* bench/core_result_checker.sv */
// result checker for the byte risc core: predicts each result word and compares
`timescale 1ns / 1ps

module core_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [tbrc_pkg::ADDR_W-1:0] s_mem_address,
    input  logic [tbrc_pkg::DATA_W-1:0] s_write_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_status,
    input  logic [tbrc_pkg::DATA_W-1:0] m_read_data,
    input  logic [tbrc_pkg::ADDR_W-1:0] m_pc_after,
    input  logic                        m_reg_written,
    input  logic [tbrc_pkg::RIDX_W-1:0] m_reg_index,
    input  logic [tbrc_pkg::DATA_W-1:0] m_reg_value,
    output int unsigned                 mismatches,
    output int unsigned                 outstanding
);

    localparam int DW = tbrc_pkg::DATA_W;
    localparam int AW = tbrc_pkg::ADDR_W;
    localparam int RW = tbrc_pkg::RIDX_W;

    typedef struct packed {
        logic          status;
        logic [DW-1:0] read_data;
        logic [AW-1:0] pc_after;
        logic          reg_written;
        logic [RW-1:0] reg_index;
        logic [DW-1:0] reg_value;
    } core_result_t;

    // shadow copy of the core state
    logic [DW-1:0] mem_img [tbrc_pkg::MEM_DEPTH];
    logic [DW-1:0] reg_img [tbrc_pkg::RF_DEPTH];
    logic [AW-1:0] pc_img;

    core_result_t pending_results [$];

    function automatic string fmt_result(input core_result_t r);
        return $sformatf("status=%0d rdata=%02h pc=%04h wr=%0d idx=%0d val=%02h",
                         r.status, r.read_data, r.pc_after, r.reg_written,
                         r.reg_index, r.reg_value);
    endfunction

    // applies one input word to the shadow state and returns its result word
    function automatic core_result_t predict_word(input logic [1:0] act,
                                                  input logic [AW-1:0] addr,
                                                  input logic [DW-1:0] wdata);
        core_result_t        r;
        logic [DW-1:0]       b0, b1, va, vb, res;
        logic [AW-1:0]       pc_plus1, pair, next_pc;
        logic [RW-1:0]       dst;
        tbrc_pkg::opcode_t   op;
        logic                wr;
        r = '0;
        case (act)
            tbrc_pkg::ACT_WRITE: mem_img[addr] = wdata;
            tbrc_pkg::ACT_READ:  r.read_data = mem_img[addr];
            tbrc_pkg::ACT_EXEC: begin
                pc_plus1 = pc_img + 16'd1;
                b0       = mem_img[pc_img];
                b1       = mem_img[pc_plus1];
                op       = tbrc_pkg::opcode_t'(b0[7:4]);
                dst      = b0[3:0];
                va       = reg_img[b1[7:4]];
                vb       = reg_img[b1[3:0]];
                pair     = {va, vb};
                next_pc  = pc_img + 16'd2;
                wr       = 1'b1;
                res      = '0;
                case (op)
                    tbrc_pkg::OP_ADD: res = va + vb;
                    tbrc_pkg::OP_SUB: res = va - vb;
                    tbrc_pkg::OP_MUL: res = va * vb;
                    tbrc_pkg::OP_MOD: begin
                        if (vb == '0) begin
                            r.status = 1'b1;
                            wr       = 1'b0;
                        end else begin
                            res = va % vb;
                        end
                    end
                    tbrc_pkg::OP_AND: res = va & vb;
                    tbrc_pkg::OP_NOT: res = ~va;
                    tbrc_pkg::OP_OR:  res = va | vb;
                    tbrc_pkg::OP_XOR: res = va ^ vb;
                    tbrc_pkg::OP_SAV: begin
                        mem_img[pair] = reg_img[dst];
                        wr            = 1'b0;
                    end
                    tbrc_pkg::OP_LOD: res = mem_img[pair];
                    tbrc_pkg::OP_COP: res = va;
                    tbrc_pkg::OP_EQU: res = (va == vb) ? 8'hFF : 8'h00;
                    tbrc_pkg::OP_GRT: res = (va > vb) ? 8'hFF : 8'h00;
                    tbrc_pkg::OP_JMP: begin
                        next_pc = pair;
                        wr      = 1'b0;
                    end
                    tbrc_pkg::OP_JIF: begin
                        if (reg_img[dst] != '0) next_pc = pair;
                        wr = 1'b0;
                    end
                    default: res = b1;
                endcase
                // a failed modulo leaves everything as it was
                if (!r.status) begin
                    if (wr) begin
                        reg_img[dst]  = res;
                        r.reg_written = 1'b1;
                        r.reg_index   = dst;
                        r.reg_value   = res;
                    end
                    pc_img = next_pc;
                end
            end
            default: ;
        endcase
        r.pc_after = pc_img;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        core_result_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < tbrc_pkg::MEM_DEPTH; i++) mem_img[i] = '0;
            for (int i = 0; i < tbrc_pkg::RF_DEPTH; i++) reg_img[i] = '0;
            pc_img = '0;
            pending_results.delete();
            mismatches = 0;
        end else begin
            // check before pushing so a word never meets its own expectation
            if (m_valid && m_ready) begin
                got = {m_status, m_read_data, m_pc_after, m_reg_written, m_reg_index,
                       m_reg_value};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word %s", $time, fmt_result(got));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch expected %s got %s", $time,
                                     fmt_result(want), fmt_result(got));
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_word(s_action, s_mem_address, s_write_data));
        end
        outstanding = pending_results.size();
    end

endmodule

/* bench/testbench.sv */
// testbench top for the byte risc core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int AW = tbrc_pkg::ADDR_W;
    localparam int DW = tbrc_pkg::DATA_W;
    localparam int RW = tbrc_pkg::RIDX_W;

    // the action code the core ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic          aclk          = 1'b0;
    logic          aresetn       = 1'b0;
    logic          s_valid       = 1'b0;
    logic          s_ready;
    logic [1:0]    s_action      = tbrc_pkg::ACT_WRITE;
    logic [AW-1:0] s_mem_address = '0;
    logic [DW-1:0] s_write_data  = '0;
    logic          m_valid;
    logic          m_ready       = 1'b0;
    logic          m_status;
    logic [DW-1:0] m_read_data;
    logic [AW-1:0] m_pc_after;
    logic          m_reg_written;
    logic [RW-1:0] m_reg_index;
    logic [DW-1:0] m_reg_value;

    int unsigned mismatches;
    int unsigned outstanding;

    // idle chances in percent per cycle, changed per phase
    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 52;

    // words accepted by the core, and those of them it does not ignore
    int unsigned words_sent   = 0;
    int unsigned useful_items = 0;

    // result words seen on the output, and the pc the latest one carried
    int unsigned   results_back = 0;
    logic [AW-1:0] last_pc      = '0;

    // where the next instruction has to be placed
    logic [AW-1:0] prog_pc      = '0;
    logic [AW-1:0] last_wr_addr = '0;

    always #4 aclk = ~aclk;

    tiny_byte_risc_core_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_mem_address (s_mem_address),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_data   (m_read_data),
        .m_pc_after    (m_pc_after),
        .m_reg_written (m_reg_written),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value)
    );

    core_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_mem_address (s_mem_address),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_data   (m_read_data),
        .m_pc_after    (m_pc_after),
        .m_reg_written (m_reg_written),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // receiver stalls at random, one fresh decision per cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // count result words; the values are updated with nonblocking assignments, which keeps the
    // stimulus process free of same-step ordering
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            results_back <= results_back + 1;
            last_pc      <= m_pc_after;
        end
    end

    // offer one word, with a random gap first; valid stays high on return so
    // a following word can go out back to back
    task automatic send_word(input logic [1:0] act, input logic [AW-1:0] addr,
                             input logic [DW-1:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_mem_address <= addr;
        s_write_data  <= data;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (act != ACT_UNUSED) useful_items++;
    endtask

    // execute whatever sits at the pc, then learn the new pc from the result
    task automatic run_exec();
        send_word(tbrc_pkg::ACT_EXEC, AW'($urandom()), DW'($urandom()));
        s_valid <= 1'b0;
        while (results_back != words_sent) @(posedge aclk);
        prog_pc = last_pc;
    endtask

    // place one instruction at the pc (second byte wraps past 0xffff) and run it
    task automatic run_instr(input tbrc_pkg::opcode_t op, input logic [RW-1:0] dst,
                             input logic [DW-1:0] lo);
        send_word(tbrc_pkg::ACT_WRITE, prog_pc, {op, dst});
        send_word(tbrc_pkg::ACT_WRITE, prog_pc + 16'd1, lo);
        run_exec();
    endtask

    initial begin : stimulus
        int unsigned       pick;
        int unsigned       op_sweep;
        tbrc_pkg::opcode_t op;
        logic [RW-1:0]     dst;
        logic [DW-1:0]     lo;
        logic [AW-1:0]     addr;

        op_sweep = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // the clearing pass after reset is covered by waiting on s_ready

        // memory words at the address and data extremes and one in between; the last two read back
        send_word(tbrc_pkg::ACT_WRITE, 16'h0000, 8'h00);
        send_word(tbrc_pkg::ACT_WRITE, 16'hFFFF, 8'hFF);
        send_word(tbrc_pkg::ACT_WRITE, 16'hA5A5, 8'h5A);
        send_word(tbrc_pkg::ACT_READ, 16'hFFFF, 8'h00);
        send_word(tbrc_pkg::ACT_READ, 16'hA5A5, 8'hFF);
        // never written, reads the cleared value
        send_word(tbrc_pkg::ACT_READ, 16'h1234, 8'h00);
        // the ignored action with every payload bit high
        send_word(ACT_UNUSED, 16'hFFFF, 8'hFF);

        // modulo by zero: r1 % r0 with both still zero, nothing may change
        run_instr(tbrc_pkg::OP_MOD, 4'd4, 8'h10);

        // jump to 0xffff so the second instruction byte comes from address 0
        run_instr(tbrc_pkg::OP_SET, 4'd1, 8'hFF);
        run_instr(tbrc_pkg::OP_SET, 4'd2, 8'hFF);
        run_instr(tbrc_pkg::OP_JMP, 4'd0, 8'h12);
        run_instr(tbrc_pkg::OP_SET, 4'd3, 8'h5A);

        // conditional jump on a zero register, not taken
        run_instr(tbrc_pkg::OP_JIF, 4'd0, 8'h12);

        // random part in three idling phases
        while (useful_items < 550) begin
            if (useful_items >= 370) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (useful_items >= 185) begin
                send_idle_pct = 52;
                recv_idle_pct = 20;
            end

            pick = $urandom_range(99);
            if (pick < 70) begin
                // well-formed instruction; the first sixteen sweep every opcode
                if (op_sweep < 16)
                    op = tbrc_pkg::opcode_t'(op_sweep[3:0]);
                else if ($urandom_range(3) == 0)
                    op = tbrc_pkg::OP_SET;
                else
                    op = tbrc_pkg::opcode_t'($urandom_range(15));
                op_sweep++;
                // low registers get reused often so loads meet earlier stores
                if ($urandom_range(1)) dst = RW'($urandom_range(3));
                else dst = RW'($urandom_range(15));
                if (op == tbrc_pkg::OP_SET) begin
                    case ($urandom_range(3))
                        0:       lo = 8'h00;
                        1:       lo = 8'hFF;
                        2:       lo = 8'h01;
                        default: lo = DW'($urandom_range(255));
                    endcase
                end else begin
                    lo = DW'($urandom_range(255));
                    if ($urandom_range(1)) lo = lo & 8'h33;
                end
                run_instr(op, dst, lo);
            end else if (pick < 78) begin
                last_wr_addr = AW'($urandom());
                send_word(tbrc_pkg::ACT_WRITE, last_wr_addr, DW'($urandom()));
            end else if (pick < 86) begin
                if ($urandom_range(1)) addr = last_wr_addr;
                else addr = AW'($urandom());
                send_word(tbrc_pkg::ACT_READ, addr, DW'($urandom()));
            end else if (pick < 94) begin
                // run whatever memory holds at the pc
                run_exec();
            end else begin
                send_word(ACT_UNUSED, AW'($urandom()), DW'($urandom()));
            end
        end

        s_valid <= 1'b0;
        while (results_back != words_sent) @(posedge aclk);
        // the longest instruction is a modulo; leave room for a stray word
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // clearing pass over 65536 memory bytes plus a few hundred words, many times over
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/tbrc_pkg.sv
rtl/tbrc_mod_unit.sv
rtl/tbrc_datapath.sv
rtl/tbrc_ctrl.sv
rtl/tiny_byte_risc_core_top.sv
bench/core_result_checker.sv
bench/testbench.sv
